>>> hdl/rtlg_pkg.sv
`default_nettype none

package rtlg_pkg;

    // Sizes
    localparam int SLOTS         = 256;
    localparam int SLOT_BITS     = $clog2(SLOTS);
    localparam int LOC_BITS      = 24;
    localparam int TOTAL_BITS    = LOC_BITS + 1;
    localparam int SUM_BITS      = LOC_BITS + 2;
    localparam int OFFSET_BITS   = 24;
    localparam int ROWS_BITS     = 16;
    localparam int LEVEL_BITS    = 16;
    localparam int RECORD_BITS   = 32;
    localparam int CODE_BITS     = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Mode codes
    localparam logic [1:0] MODE_RECORD   = 2'd0;
    localparam logic [1:0] MODE_CHANNELS = 2'd1;
    localparam logic [1:0] MODE_LEVELS   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE         = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEEP_LEVELS  = 2'd2;

    // First location past the addressable range
    localparam logic [SUM_BITS-1:0] LOC_CAP = {2'b01, {LOC_BITS{1'b0}}};
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    typedef struct packed {
        logic                   first_row;
        logic [RECORD_BITS-1:0] record_number;
        logic [CODE_BITS-1:0]   variable_code;
        logic [LEVEL_BITS-1:0]  level_count;
    } rtlg_in_t;

    typedef struct packed {
        logic [LOC_BITS-1:0] location;
        logic                opens_location;
        logic                kept;
        logic                overflow;
    } rtlg_out_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic [ROWS_BITS-1:0] max_channels;
        logic                 keep_levels;
    } rtlg_cfg_t;

    // Classified row handed from the front to the back
    typedef struct packed {
        logic                  first_row;
        logic                  new_profile;
        logic [SLOT_BITS-1:0]  slot;
        logic [LEVEL_BITS-1:0] levels;
    } rtlg_job_t;

    // One per-variable counter entry
    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [ROWS_BITS-1:0]   rows;
    } rtlg_entry_t;

    // Unused mode code behaves as group-by-record
    function automatic logic [1:0] norm_mode(input logic [1:0] m);
        logic [1:0] r;
        case (m)
            MODE_CHANNELS: r = MODE_CHANNELS;
            MODE_LEVELS:   r = MODE_LEVELS;
            default:       r = MODE_RECORD;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rtlg_front.sv
`default_nettype none

module rtlg_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rtlg_pkg::rtlg_in_t in_data,
    input  wire rtlg_pkg::rtlg_cfg_t cfg,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output rtlg_pkg::rtlg_job_t     job
);
    import rtlg_pkg::*;

    logic [RECORD_BITS-1:0] last_record_reg, last_record_next;
    logic                   started_reg, started_next;
    logic                   empty_reg, empty_next;   // location count is zero
    logic                   push;
    logic                   new_profile;
    logic                   start_drop;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign push      = in_valid && job_ready;

    // Profile detection
    always_comb
    begin
        new_profile = in_data.first_row || !started_reg || empty_reg
                      || (in_data.record_number != last_record_reg);
        // a profile's first row sees offset 0, so it drops only on zero levels
        start_drop  = (norm_mode(cfg.mode) == MODE_LEVELS) && cfg.keep_levels
                      && (in_data.level_count == '0);

        job.first_row   = in_data.first_row;
        job.new_profile = new_profile;
        job.slot        = in_data.variable_code[SLOT_BITS-1:0];
        job.levels      = in_data.level_count;

        last_record_next = last_record_reg;
        started_next     = started_reg;
        empty_next       = empty_reg;
        if (push)
        begin
            started_next = 1'b1;
            if (new_profile)
                last_record_next = in_data.record_number;
            // count stays zero only while the opening row is dropped
            empty_next = (in_data.first_row || empty_reg) && start_drop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_record_reg <= '0;
            started_reg     <= 1'b0;
            empty_reg       <= 1'b1;
        end
        else
        begin
            last_record_reg <= last_record_next;
            started_reg     <= started_next;
            empty_reg       <= empty_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rtlg_queue.sv
`default_nettype none

module rtlg_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire rtlg_pkg::rtlg_job_t push_data,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output rtlg_pkg::rtlg_job_t      pop_data
);
    import rtlg_pkg::*;

    rtlg_job_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

>>> hdl/rtlg_back.sv
`default_nettype none

module rtlg_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rtlg_pkg::rtlg_cfg_t cfg,
    input  wire logic                job_valid,
    output logic                     job_ready,
    input  wire rtlg_pkg::rtlg_job_t job,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rtlg_pkg::rtlg_out_t      out_data
);
    import rtlg_pkg::*;

    // Counter memory and per-slot valid bits
    rtlg_entry_t            mem [SLOTS];
    logic [SLOTS-1:0]       valid_reg, valid_next;
    rtlg_entry_t            rd_reg;

    // Forwarding of the write made on the edge the current row was loaded
    logic                   fwd_valid_reg;
    logic [SLOT_BITS-1:0]   fwd_slot_reg;
    rtlg_entry_t            fwd_data_reg;

    // Execute stage
    logic                   busy_reg;
    rtlg_job_t              job_reg;

    // Profile state
    logic [TOTAL_BITS-1:0]  total_reg, total_next;
    logic [TOTAL_BITS-1:0]  pfl_reg, pfl_next;
    logic [LEVEL_BITS-1:0]  levels_reg, levels_next;

    // Output register
    logic                   out_valid_reg;
    rtlg_out_t              out_reg;

    logic                   fire, load;
    logic [1:0]             m;
    logic                   hit;
    rtlg_entry_t            cur;
    logic [OFFSET_BITS-1:0] offset, offset_new;
    logic [ROWS_BITS-1:0]   rows, rows_new, rows_inc;
    logic [TOTAL_BITS-1:0]  total_eff;
    logic [TOTAL_BITS-1:0]  pfl_eff;
    logic [LEVEL_BITS-1:0]  levels_eff;
    logic [SUM_BITS-1:0]    loc;
    logic                   drop;
    logic                   wr;
    rtlg_out_t              result;

    assign fire      = busy_reg && (!out_valid_reg || out_ready);
    assign load      = job_valid && (!busy_reg || fire);
    assign job_ready = !busy_reg || fire;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Lookup, placement and counter update
    always_comb
    begin
        m          = norm_mode(cfg.mode);
        total_eff  = job_reg.first_row ? '0 : total_reg;
        pfl_eff    = job_reg.new_profile ? total_eff : pfl_reg;
        levels_eff = job_reg.new_profile ? job_reg.levels : levels_reg;

        if (fwd_valid_reg && (fwd_slot_reg == job_reg.slot))
        begin
            cur = fwd_data_reg;
            hit = 1'b1;
        end
        else
        begin
            cur = rd_reg;
            hit = valid_reg[job_reg.slot];
        end
        // a new profile sees every counter cleared
        hit = hit && !job_reg.new_profile && (m != MODE_RECORD);

        offset = hit ? cur.offset : '0;
        rows   = hit ? cur.rows : '0;

        drop = (m == MODE_LEVELS) && cfg.keep_levels
               && (offset >= OFFSET_BITS'(levels_eff));

        loc = SUM_BITS'(pfl_eff) + SUM_BITS'(offset);

        result     = '0;
        total_next = total_eff;
        if (!drop)
        begin
            result.kept = 1'b1;
            if (loc >= LOC_CAP)
            begin
                result.location = '1;
                result.overflow = 1'b1;
            end
            else if (loc >= SUM_BITS'(total_eff))
            begin
                result.location       = total_eff[LOC_BITS-1:0];
                result.opens_location = 1'b1;
                total_next            = total_eff + 1'b1;
            end
            else
                result.location = loc[LOC_BITS-1:0];
        end

        // counter advance
        rows_inc   = rows + 1'b1;
        rows_new   = rows;
        offset_new = offset;
        if (m == MODE_CHANNELS)
        begin
            rows_new = rows_inc;
            if (rows_inc == cfg.max_channels)
            begin
                rows_new = '0;
                if (offset != OFFSET_MAX)
                    offset_new = offset + 1'b1;
            end
        end
        else if (m == MODE_LEVELS)
        begin
            if (offset != OFFSET_MAX)
                offset_new = offset + 1'b1;
        end

        wr = fire && (m != MODE_RECORD) && !drop;

        pfl_next    = pfl_reg;
        levels_next = levels_reg;
        valid_next  = valid_reg;
        if (fire)
        begin
            pfl_next    = pfl_eff;
            levels_next = levels_eff;
            if (job_reg.new_profile)
                valid_next = '0;
            if (wr)
                valid_next[job_reg.slot] = 1'b1;
        end
        if (!fire)
            total_next = total_reg;
    end

    // Control and profile state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            valid_reg     <= '0;
            total_reg     <= '0;
            pfl_reg       <= '0;
            levels_reg    <= '1;
        end
        else
        begin
            valid_reg  <= valid_next;
            total_reg  <= total_next;
            pfl_reg    <= pfl_next;
            levels_reg <= levels_next;
            if (load)
            begin
                busy_reg      <= 1'b1;
                fwd_valid_reg <= wr;
            end
            else if (fire)
                busy_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg      <= job;
            fwd_slot_reg <= job_reg.slot;
            fwd_data_reg <= '{offset: offset_new, rows: rows_new};
        end
        if (fire)
            out_reg <= result;
    end

    // Counter memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr)
            mem[job_reg.slot] <= '{offset: offset_new, rows: rows_new};
        if (load)
            rd_reg <= mem[job.slot];
    end

endmodule

`default_nettype wire

>>> hdl/row_to_location_grouper_core.sv
// Channel   Direction  Signals                              Transaction
// in        in         in_valid, in_ready, in_data          one table row
// out       out        out_valid, out_ready, out_data       one placement per row
// cfg       in         cfg_wr_en, cfg_index, cfg_data       one register write
//
// One row per cycle sustained while the output is not stalled; a row passes
// through the queue, the counter memory read and the output register.
// The counter memory gives one read-modify-write per row; a row that follows
// the same variable picks up the previous write through a forwarding register.
// Reset returns profile state to its initial values and clears the per-variable valid bits at once.
// Either side may stall on its own; the two-entry queue and output register
// keep the other side moving.
`default_nettype none

module row_to_location_grouper_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire rtlg_pkg::rtlg_in_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output rtlg_pkg::rtlg_out_t                      out_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rtlg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [rtlg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rtlg_pkg::*;

    rtlg_cfg_t cfg_reg, cfg_next;
    logic      fq_valid, fq_ready;
    rtlg_job_t fq_job;
    logic      qb_valid, qb_ready;
    rtlg_job_t qb_job;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MODE:         cfg_next.mode         = cfg_data[1:0];
                CFG_MAX_CHANNELS: cfg_next.max_channels = cfg_data[ROWS_BITS-1:0];
                CFG_KEEP_LEVELS:  cfg_next.keep_levels  = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{mode: MODE_RECORD, max_channels: ROWS_BITS'(1), keep_levels: 1'b0};
        else
            cfg_reg <= cfg_next;
    end

    rtlg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    rtlg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    rtlg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A dropped row carries no placement
    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.kept) |->
            (out_data.location == '0 && !out_data.opens_location && !out_data.overflow))
        else $error("dropped row carries a placement");

    // A saturated row never opens a location
    a_ovf_no_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.overflow && out_data.opens_location))
        else $error("overflow and open together");

    // Saturation pins the location at the top index
    a_ovf_loc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.overflow) |-> (out_data.location == '1))
        else $error("overflow row not at top location");

endmodule

`default_nettype wire

>>> sim/tb.sv
module tb;
    import rtlg_pkg::*;

    // Tag value that no profile ever uses
    localparam logic [15:0] TAG_FREE = 16'hFFFF;
    // Unused mode code, expected to act as group-by-record
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int PHASE_ROWS = 42;

    typedef enum logic {STEP_ROW, STEP_SET} step_kind_e;

    typedef struct {
        step_kind_e  kind;
        rtlg_in_t    row;
        bit          known;
        rtlg_out_t   want;
        logic [1:0]  mode;
        logic [15:0] max_ch;
        logic        keep;
    } dir_step_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    rtlg_in_t                 in_data;
    logic                     out_valid;
    logic                     out_ready;
    rtlg_out_t                out_data;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // Mirror of the block's registers and profile state
    logic [1:0]             set_mode;
    logic [15:0]            set_max_ch;
    logic                   set_keep;
    logic [31:0]            last_rec;
    logic                   seen_row;
    logic [TOTAL_BITS-1:0]  loc_count;
    logic [TOTAL_BITS-1:0]  prof_base;
    logic [15:0]            prof_levels;
    logic [15:0]            prof_tag;
    logic [OFFSET_BITS-1:0] slot_offset [SLOTS];
    logic [15:0]            slot_rows [SLOTS];
    logic [15:0]            slot_tag [SLOTS];

    rtlg_out_t   pending_places [$];
    dir_step_t   directed_steps [$];
    int          errors = 0;
    bit          quiet = 1'b0;
    int          ready_hold = 0;
    logic [31:0] next_rec = 32'd100;

    row_to_location_grouper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Place one row: returns its expected placement and advances the mirror
    function automatic rtlg_out_t place_row(input rtlg_in_t r);
        rtlg_out_t           res;
        logic [1:0]          m;
        logic [7:0]          s;
        logic [23:0]         off;
        logic [15:0]         rows;
        logic [15:0]         nxt;
        logic [SUM_BITS-1:0] loc;
        int                  i;
        res = '0;
        res.kept = 1'b1;
        m = (set_mode == MODE_CHANNELS || set_mode == MODE_LEVELS) ? set_mode : MODE_RECORD;
        s = r.variable_code;
        if (r.first_row)
            loc_count = '0;
        // new profile: fresh tag clears every slot at once
        if (r.first_row || !seen_row || loc_count == '0 || r.record_number != last_rec)
        begin
            nxt = prof_tag + 16'd1;
            if (nxt == TAG_FREE)
            begin
                for (i = 0; i < SLOTS; i++)
                    slot_tag[i] = TAG_FREE;
                nxt = '0;
            end
            prof_tag = nxt;
            prof_base = loc_count;
            prof_levels = r.level_count;
            last_rec = r.record_number;
        end
        seen_row = 1'b1;
        off = '0;
        rows = '0;
        if (m != MODE_RECORD && slot_tag[s] == prof_tag)
        begin
            off = slot_offset[s];
            rows = slot_rows[s];
        end
        // level beyond the reported count: dropped, nothing else moves
        if (m == MODE_LEVELS && set_keep && off >= OFFSET_BITS'(prof_levels))
        begin
            res = '0;
            return res;
        end
        loc = SUM_BITS'(prof_base) + SUM_BITS'(off);
        if (loc >= LOC_CAP)
        begin
            res.location = '1;
            res.overflow = 1'b1;
        end
        else if (loc >= SUM_BITS'(loc_count))
        begin
            res.location = loc_count[LOC_BITS-1:0];
            res.opens_location = 1'b1;
            loc_count = loc_count + 1'b1;
        end
        else
            res.location = loc[LOC_BITS-1:0];
        if (m == MODE_CHANNELS)
        begin
            rows = rows + 16'd1;
            if (rows == set_max_ch)
            begin
                rows = '0;
                if (off < OFFSET_MAX)
                    off = off + 24'd1;
            end
        end
        else if (m == MODE_LEVELS)
        begin
            if (off < OFFSET_MAX)
                off = off + 24'd1;
        end
        if (m != MODE_RECORD)
        begin
            slot_offset[s] = off;
            slot_rows[s] = rows;
            slot_tag[s] = prof_tag;
        end
        return res;
    endfunction

    task automatic add_row(input logic first, input logic [31:0] rec,
                           input logic [7:0] code, input logic [15:0] lev);
        dir_step_t st;
        st = '{STEP_ROW, '{first, rec, code, lev}, 1'b0, '0, MODE_RECORD, 16'd0, 1'b0};
        directed_steps = {directed_steps, st};
    endtask

    task automatic add_known(input logic first, input logic [31:0] rec,
                             input logic [7:0] code, input logic [15:0] lev,
                             input logic [23:0] loc, input logic op, input logic kp,
                             input logic ov);
        dir_step_t st;
        st = '{STEP_ROW, '{first, rec, code, lev}, 1'b1, '{loc, op, kp, ov},
               MODE_RECORD, 16'd0, 1'b0};
        directed_steps = {directed_steps, st};
    endtask

    task automatic add_setting(input logic [1:0] m, input logic [15:0] mc, input logic k);
        dir_step_t st;
        st = '{STEP_SET, '0, 1'b0, '0, m, mc, k};
        directed_steps = {directed_steps, st};
    endtask

    // Offer one row after a random gap, wait for the transaction, then predict
    task automatic send_row(input rtlg_in_t r, input bit known, input rtlg_out_t want);
        int        gap;
        int        p;
        rtlg_out_t pred;
        gap = 0;
        if (!quiet)
        begin
            p = $urandom_range(0, 99);
            if (p < 55)
                gap = 0;
            else if (p < 88)
                gap = $urandom_range(1, 3);
            else if (p < 97)
                gap = $urandom_range(4, 9);
            else
                gap = $urandom_range(12, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = place_row(r);
        pending_places = {pending_places, (known ? want : pred)};
    endtask

    // Drop valid, let every placement come out, then cover the pipeline depth
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_places.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [1:0] m, input logic [15:0] mc, input logic k);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= 16'(m);
        @(posedge clk);
        cfg_index <= CFG_MAX_CHANNELS;
        cfg_data  <= mc;
        @(posedge clk);
        cfg_index <= CFG_KEEP_LEVELS;
        cfg_data  <= 16'(k);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        set_mode = m;
        set_max_ch = mc;
        set_keep = k;
    endtask

    // Receiver back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk)
    begin : ready_gen
        int p;
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (quiet)
            out_ready <= 1'b1;
        else
        begin
            p = $urandom_range(0, 99);
            if (p < 60)
            begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end
            else if (p < 93)
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    // Compare each output transaction with the oldest pending placement
    always @(posedge clk)
    begin : check_out
        rtlg_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_places.size() == 0)
            begin
                $error("unexpected placement: location %0d", out_data.location);
                errors++;
            end
            else
            begin
                want = pending_places.pop_front();
                if (out_data.location !== want.location)
                begin
                    $error("location: expected %0d, got %0d", want.location, out_data.location);
                    errors++;
                end
                if (out_data.opens_location !== want.opens_location)
                begin
                    $error("opens_location: expected %0b, got %0b",
                           want.opens_location, out_data.opens_location);
                    errors++;
                end
                if (out_data.kept !== want.kept)
                begin
                    $error("kept: expected %0b, got %0b", want.kept, out_data.kept);
                    errors++;
                end
                if (out_data.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        rtlg_in_t    r;
        logic [7:0]  pool [3];
        logic [15:0] lev;
        logic        start_first;
        int          k, n, j, p, npool, len, sent;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data  = '0;
        rst_n     = 1'b0;

        // mirror starts from the reset state
        set_mode    = MODE_RECORD;
        set_max_ch  = 16'd1;
        set_keep    = 1'b0;
        last_rec    = '0;
        seen_row    = 1'b0;
        loc_count   = '0;
        prof_base   = '0;
        prof_levels = 16'hFFFF;
        prof_tag    = '0;
        for (k = 0; k < SLOTS; k++)
        begin
            slot_offset[k] = '0;
            slot_rows[k]   = '0;
            slot_tag[k]    = TAG_FREE;
        end

        // directed rows: reset values, record extremes, each mode
        add_known(1'b1, 32'd0, 8'd0, 16'd0, 24'd0, 1'b1, 1'b1, 1'b0);
        add_known(1'b0, 32'd0, 8'hFF, 16'hFFFF, 24'd0, 1'b0, 1'b1, 1'b0);
        add_known(1'b0, 32'hFFFF_FFFF, 8'd7, 16'd1, 24'd1, 1'b1, 1'b1, 1'b0);
        add_known(1'b1, 32'hFFFF_FFFF, 8'd128, 16'd0, 24'd0, 1'b1, 1'b1, 1'b0);
        add_setting(MODE_CHANNELS, 16'd2, 1'b0);
        add_row(1'b0, 32'd5, 8'd3, 16'd4);
        add_row(1'b0, 32'd5, 8'd3, 16'd0);
        add_row(1'b0, 32'd5, 8'd3, 16'd0);
        add_row(1'b0, 32'd5, 8'd4, 16'd0);
        add_row(1'b0, 32'd5, 8'd3, 16'd0);
        // zero channel limit wraps the row counter
        add_setting(MODE_CHANNELS, 16'd0, 1'b1);
        add_row(1'b0, 32'd6, 8'd1, 16'd0);
        add_row(1'b0, 32'd6, 8'd1, 16'd0);
        // levels with dropping: third level of a two-level profile goes
        add_setting(MODE_LEVELS, 16'd1, 1'b1);
        add_row(1'b0, 32'd9, 8'd10, 16'd2);
        add_row(1'b0, 32'd9, 8'd10, 16'd0);
        add_known(1'b0, 32'd9, 8'd10, 16'd0, 24'd0, 1'b0, 1'b0, 1'b0);
        add_row(1'b0, 32'd9, 8'd11, 16'd0);
        // zero levels drop the first row; the count stays empty, so a new profile follows
        add_known(1'b1, 32'd12, 8'd2, 16'd0, 24'd0, 1'b0, 1'b0, 1'b0);
        add_known(1'b0, 32'd12, 8'd2, 16'd3, 24'd0, 1'b1, 1'b1, 1'b0);
        // spare mode code
        add_setting(MODE_SPARE, 16'hFFFF, 1'b1);
        add_row(1'b0, 32'd20, 8'd0, 16'd0);
        add_row(1'b0, 32'd20, 8'd0, 16'd0);
        add_setting(MODE_LEVELS, 16'd1, 1'b0);
        add_row(1'b0, 32'd30, 8'd5, 16'd1);
        add_row(1'b0, 32'd30, 8'd5, 16'd1);
        add_row(1'b0, 32'd30, 8'd5, 16'd1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < directed_steps.size(); k++)
        begin
            if (directed_steps[k].kind == STEP_SET)
            begin
                wait_idle();
                apply_setting(directed_steps[k].mode, directed_steps[k].max_ch,
                              directed_steps[k].keep);
            end
            else
                send_row(directed_steps[k].row, directed_steps[k].known,
                         directed_steps[k].want);
        end

        // random phases, one register setting each
        for (n = 0; n < 10; n++)
        begin
            wait_idle();
            case (n)
                0: apply_setting(MODE_RECORD, 16'd1, 1'b0);
                1: apply_setting(MODE_CHANNELS, 16'd1, 1'b0);
                2: apply_setting(MODE_CHANNELS, 16'd2, 1'b1);
                3: apply_setting(MODE_CHANNELS, 16'hFFFF, 1'b0);
                4: apply_setting(MODE_CHANNELS, 16'd0, 1'b1);
                5: apply_setting(MODE_LEVELS, 16'd7, 1'b1);
                6: apply_setting(MODE_LEVELS, 16'd0, 1'b0);
                7: apply_setting(MODE_SPARE, 16'd5, 1'b1);
                8: apply_setting(MODE_CHANNELS, 16'($urandom_range(1, 6)),
                                 ($urandom_range(0, 1) == 0));
                default: apply_setting(MODE_LEVELS, 16'($urandom), 1'b1);
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_ROWS)
            begin
                p = $urandom_range(0, 99);
                if (p < 10)
                begin
                    // noise row
                    r.first_row     = ($urandom_range(0, 7) == 0);
                    r.record_number = $urandom;
                    r.variable_code = 8'($urandom);
                    r.level_count   = 16'($urandom);
                    send_row(r, 1'b0, '0);
                    sent++;
                end
                else
                begin
                    // a profile: one record, a few variables repeating
                    p = $urandom_range(0, 99);
                    start_first = 1'b0;
                    if (p < 60)
                        next_rec = next_rec + 32'd1;
                    else if (p < 80)
                        next_rec = $urandom;
                    else if (p < 90)
                        start_first = 1'b1;
                    else
                        next_rec = next_rec + 32'($urandom_range(2, 9));
                    if ($urandom_range(0, 9) == 0)
                        start_first = 1'b1;
                    npool = $urandom_range(1, 3);
                    for (j = 0; j < 3; j++)
                        pool[j] = 8'($urandom);
                    lev = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 4))
                                                     : 16'($urandom);
                    len = $urandom_range(1, 10);
                    for (j = 0; j < len && sent < PHASE_ROWS; j++)
                    begin
                        r.first_row     = (j == 0) ? start_first : ($urandom_range(0, 30) == 0);
                        r.record_number = next_rec;
                        r.variable_code = pool[$urandom_range(0, npool - 1)];
                        r.level_count   = (j == 0) ? lev : 16'($urandom);
                        send_row(r, 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        wait_idle();
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin : watchdog
        #40000000;
        $display("tb: errors");
        $finish;
    end

endmodule

>>> files.f
hdl/rtlg_pkg.sv
hdl/rtlg_front.sv
hdl/rtlg_queue.sv
hdl/rtlg_back.sv
hdl/row_to_location_grouper_core.sv
sim/tb.sv
